// File: hw/rtl/dccpd_pkg.sv
// ----------------------------------------------------------------------------
// dccpd_pkg
// Shared types and constants of the dcc bit and packet decoder: result
// status codes, configuration register indexes, reset values and the
// result record.
// ----------------------------------------------------------------------------
`default_nettype none

package dccpd_pkg;

  // largest packet held, check byte included
  localparam int unsigned PacketBytesMaxDefault = 6;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ONE_MIN      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ONE_MAX      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_MIN     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_MAX     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PREAMBLE_MIN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_28     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PRIMARY_ADDR = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_OWN_ADDR     = 3'd7;

  // register reset values
  localparam logic [15:0] ONE_MIN_RST      = 16'd52;
  localparam logic [15:0] ONE_MAX_RST      = 16'd64;
  localparam logic [15:0] ZERO_MIN_RST     = 16'd90;
  localparam logic [15:0] ZERO_MAX_RST     = 16'd10000;
  localparam logic [5:0]  PREAMBLE_MIN_RST = 6'd10;
  localparam logic        SPEED_28_RST     = 1'b0;
  localparam logic [6:0]  PRIMARY_ADDR_RST = 7'd3;
  localparam logic [10:0] OWN_ADDR_RST     = 11'd0;

  localparam logic [5:0]  PREAMBLE_SAT   = 6'd63;
  localparam logic [10:0] BCAST_BASIC    = 11'h03F;
  localparam logic [10:0] BCAST_EXT      = 11'h33F;
  localparam logic [7:0]  IDLE_ADDR_BYTE = 8'hFF;
  localparam logic [7:0]  EXT_P1_MASK    = 8'h85;
  localparam logic [7:0]  EXT_P1_MATCH   = 8'h01;
  localparam logic [3:0]  BIT_START      = 4'd8;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_IDLE       = 4'd1,
    ST_RESET      = 4'd2,
    ST_BASELINE   = 4'd3,
    ST_BASIC_ACC  = 4'd4,
    ST_EXT_ACC    = 4'd5,
    ST_CHECK_FAIL = 4'd6,
    ST_BASE_ADDR  = 4'd7,
    ST_BASE_INSTR = 4'd8,
    ST_BAD_BIT    = 4'd9,
    ST_BAD_LENGTH = 4'd10
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [2:0]  packet_length;
    logic [10:0] address;
    logic        addressed_to_me;
    logic        broadcast;
    logic [4:0]  speed_step;
    logic        emergency_stop;
    logic        direction;
    logic        activate;
    logic [4:0]  data_bits;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/dcc_bit_and_packet_decoder_core.sv
// ----------------------------------------------------------------------------
// dcc_bit_and_packet_decoder_core
// Classes measured half-bit periods of a track signal, pairs them into bits,
// counts the preamble, gathers packet bytes and classes finished packets.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | beat
//  ---------+-----------+---------------------------+-----------------------------
//  in       | in        | in_valid_i / in_ready_o   | half_period_us_i
//  out      | out       | out_valid_o / out_ready_i | status_o .. data_bits_o
//  cfg      | in        | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// one beat per cycle sustained while the result register is free or read; a
// beat passes the input register, then a decode that ends a packet or reports
// an error goes into the result register. decode updates the bit/packet state
// of one half period per cycle. a held result stalls the input register only;
// a new beat is still taken while it drains into a free result register. reset
// clears control and decoder state and loads register defaults; no clearing pass.

`default_nettype none

module dcc_bit_and_packet_decoder_core #(
  parameter int unsigned PACKET_BYTES_MAX = dccpd_pkg::PacketBytesMaxDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [15:0]                       half_period_us_i,

  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [3:0]                        status_o,
  output      logic [2:0]                        packet_length_o,
  output      logic [10:0]                       address_o,
  output      logic                              addressed_to_me_o,
  output      logic                              broadcast_o,
  output      logic [4:0]                        speed_step_o,
  output      logic                              emergency_stop_o,
  output      logic                              direction_o,
  output      logic                              activate_o,
  output      logic [4:0]                        data_bits_o,

  input  wire logic                              cfg_we_i,
  input  wire logic [dccpd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [dccpd_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import dccpd_pkg::*;

  localparam int unsigned BiW = $clog2(PACKET_BYTES_MAX);
  localparam int unsigned NW  = $clog2(PACKET_BYTES_MAX + 1);

  // configuration
  logic [15:0] one_min_q, one_max_q, zero_min_q, zero_max_q;
  logic [5:0]  preamble_min_q;
  logic        speed_28_q;
  logic [6:0]  primary_addr_q;
  logic [10:0] own_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_min_q      <= ONE_MIN_RST;
      one_max_q      <= ONE_MAX_RST;
      zero_min_q     <= ZERO_MIN_RST;
      zero_max_q     <= ZERO_MAX_RST;
      preamble_min_q <= PREAMBLE_MIN_RST;
      speed_28_q     <= SPEED_28_RST;
      primary_addr_q <= PRIMARY_ADDR_RST;
      own_addr_q     <= OWN_ADDR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ONE_MIN:      one_min_q      <= cfg_wdata_i;
        CFG_ONE_MAX:      one_max_q      <= cfg_wdata_i;
        CFG_ZERO_MIN:     zero_min_q     <= cfg_wdata_i;
        CFG_ZERO_MAX:     zero_max_q     <= cfg_wdata_i;
        CFG_PREAMBLE_MIN: preamble_min_q <= cfg_wdata_i[5:0];
        CFG_SPEED_28:     speed_28_q     <= cfg_wdata_i[0];
        CFG_PRIMARY_ADDR: primary_addr_q <= cfg_wdata_i[6:0];
        CFG_OWN_ADDR:     own_addr_q     <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic [15:0] s1_p_q, s1_p_d;
  logic        adv;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_p_d     = s1_p_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
      s1_p_d     = half_period_us_i;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_p_q <= s1_p_d;
  end

  // decoder state
  logic           half_phase_q, half_phase_d;
  logic           fh_one_q, fh_one_d;
  logic           fh_valid_q, fh_valid_d;
  logic           reading_q, reading_d;
  logic [5:0]     pre_cnt_q, pre_cnt_d;
  logic [7:0]     pkt_q [PACKET_BYTES_MAX];
  logic [7:0]     pkt_d [PACKET_BYTES_MAX];
  logic [BiW-1:0] byte_idx_q, byte_idx_d;
  logic [3:0]     bit_pos_q, bit_pos_d;

  // half classification
  logic b1, bv;
  assign b1 = (s1_p_q >= one_min_q) && (s1_p_q <= one_max_q);
  assign bv = b1 || ((s1_p_q >= zero_min_q) && (s1_p_q <= zero_max_q));

  // byte count including the byte just closed by a start bit
  logic [NW-1:0] n;
  assign n = NW'(byte_idx_q) + NW'(1);

  // packet classification, valid when an end bit closes n bytes
  result_t    ex;
  logic [7:0] xsum;
  logic [7:0] p0, p1, p2;
  logic [10:0] acc_addr;
  logic [3:0]  code;

  assign p0 = pkt_q[0];
  assign p1 = pkt_q[1];
  assign p2 = pkt_q[2];

  always_comb begin
    ex       = '0;
    xsum     = '0;
    acc_addr = '0;
    code     = p1[3:0];
    // unused bytes stay zero, so a good packet xors to zero overall
    for (int i = 0; i < PACKET_BYTES_MAX; i++) begin
      xsum = xsum ^ pkt_q[i];
    end
    ex.status = ST_OK;
    if (xsum != 8'h00) begin
      ex.status = ST_CHECK_FAIL;
    end else if (n == NW'(3)) begin
      if (p1 == 8'h00 && p0 == IDLE_ADDR_BYTE) begin
        ex.status = ST_IDLE;
      end else if (p1 == 8'h00 && p0 == 8'h00) begin
        ex.status = ST_RESET;
      end else if (p0[7:6] == 2'b10 && p1[7]) begin
        acc_addr           = {2'b00, ~p1[6:4], p0[5:0]};
        ex.status          = ST_BASIC_ACC;
        ex.address         = acc_addr;
        ex.addressed_to_me = (acc_addr == own_addr_q);
        ex.broadcast       = (acc_addr == BCAST_BASIC);
        ex.activate        = p1[3];
        ex.data_bits       = {2'b00, p1[2:0]};
      end else if (p0[7]) begin
        ex.status = ST_BASE_ADDR;
      end else if (p1[7:6] != 2'b01) begin
        ex.status = ST_BASE_INSTR;
      end else begin
        ex.status          = ST_BASELINE;
        ex.address         = {4'b0000, p0[6:0]};
        ex.addressed_to_me = (p0[6:0] == primary_addr_q);
        ex.direction       = p1[5];
        if (code == 4'd1) begin
          ex.emergency_stop = 1'b1;
        end else if (code >= 4'd2) begin
          // 28 steps: low speed bit joins below the code
          ex.speed_step = speed_28_q ? ({code, p1[4]} - 5'd3) : ({1'b0, code} - 5'd1);
        end
      end
    end else if (n == NW'(4) && p0[7:6] == 2'b10
                 && (p1 & EXT_P1_MASK) == EXT_P1_MATCH) begin
      acc_addr           = {p1[2:1], p1[6:4], p0[5:0]};
      ex.status          = ST_EXT_ACC;
      ex.address         = acc_addr;
      ex.addressed_to_me = (acc_addr == own_addr_q);
      ex.broadcast       = (acc_addr == BCAST_EXT);
      ex.data_bits       = p2[4:0];
    end
  end

  // bit pairing and packet engine
  logic emit, ended_one, set_bit;

  always_comb begin
    half_phase_d = half_phase_q;
    fh_one_d     = fh_one_q;
    fh_valid_d   = fh_valid_q;
    reading_d    = reading_q;
    pre_cnt_d    = pre_cnt_q;
    byte_idx_d   = byte_idx_q;
    bit_pos_d    = bit_pos_q;
    emit         = 1'b0;
    ended_one    = 1'b0;
    set_bit      = 1'b0;
    res_d        = '0;
    res_d.status = ST_OK;

    if (!half_phase_q) begin
      fh_one_d     = b1;
      fh_valid_d   = bv;
      half_phase_d = 1'b1;
    end else begin
      half_phase_d = 1'b0;
      if (!fh_valid_q || !bv) begin
        emit         = 1'b1;
        res_d.status = ST_BAD_BIT;
      end else if (!reading_q) begin
        if (fh_one_q && b1) begin
          if (pre_cnt_q != PREAMBLE_SAT) begin
            pre_cnt_d = pre_cnt_q + 6'd1;
          end
        end else if (fh_one_q == b1) begin
          if (pre_cnt_q >= preamble_min_q) begin
            reading_d = 1'b1;
          end else begin
            pre_cnt_d = '0;
          end
        end else begin
          // mismatched halves: slip pairing by one half
          fh_one_d     = b1;
          fh_valid_d   = 1'b1;
          half_phase_d = 1'b1;
          pre_cnt_d    = '0;
        end
      end else if (fh_one_q != b1) begin
        emit         = 1'b1;
        res_d.status = ST_BAD_BIT;
      end else if (bit_pos_q < BIT_START) begin
        set_bit   = fh_one_q;
        bit_pos_d = bit_pos_q + 4'd1;
      end else if (fh_one_q) begin
        // end bit
        emit      = 1'b1;
        ended_one = 1'b1;
        if (n >= NW'(3) && n <= NW'(PACKET_BYTES_MAX)) begin
          res_d = ex;
        end else begin
          res_d.status = ST_BAD_LENGTH;
        end
        res_d.packet_length = 3'(n);
      end else if (n >= NW'(PACKET_BYTES_MAX)) begin
        emit         = 1'b1;
        res_d.status = ST_BAD_LENGTH;
      end else begin
        byte_idx_d = BiW'(n);
        bit_pos_d  = '0;
      end
    end

    if (emit) begin
      byte_idx_d   = '0;
      bit_pos_d    = '0;
      reading_d    = 1'b0;
      half_phase_d = 1'b0;
      pre_cnt_d    = ended_one ? 6'd1 : 6'd0;
    end

    for (int i = 0; i < PACKET_BYTES_MAX; i++) begin
      pkt_d[i] = pkt_q[i];
      if (emit) begin
        pkt_d[i] = '0;
      end else if (set_bit && byte_idx_q == BiW'(i)) begin
        pkt_d[i] = pkt_q[i] | (8'h80 >> bit_pos_q[2:0]);
      end
    end

    out_valid_d = out_valid_q;
    if (adv && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_phase_q <= 1'b0;
      fh_one_q     <= 1'b0;
      fh_valid_q   <= 1'b0;
      reading_q    <= 1'b0;
      pre_cnt_q    <= '0;
      byte_idx_q   <= '0;
      bit_pos_q    <= '0;
      for (int i = 0; i < PACKET_BYTES_MAX; i++) begin
        pkt_q[i] <= '0;
      end
    end else if (adv) begin
      half_phase_q <= half_phase_d;
      fh_one_q     <= fh_one_d;
      fh_valid_q   <= fh_valid_d;
      reading_q    <= reading_d;
      pre_cnt_q    <= pre_cnt_d;
      byte_idx_q   <= byte_idx_d;
      bit_pos_q    <= bit_pos_d;
      for (int i = 0; i < PACKET_BYTES_MAX; i++) begin
        pkt_q[i] <= pkt_d[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = res_q.status;
  assign packet_length_o   = res_q.packet_length;
  assign address_o         = res_q.address;
  assign addressed_to_me_o = res_q.addressed_to_me;
  assign broadcast_o       = res_q.broadcast;
  assign speed_step_o      = res_q.speed_step;
  assign emergency_stop_o  = res_q.emergency_stop;
  assign direction_o       = res_q.direction;
  assign activate_o        = res_q.activate;
  assign data_bits_o       = res_q.data_bits;

  // checks
  a_result_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a decoded beat");

  a_byte_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_idx_q < BiW'(PACKET_BYTES_MAX) && bit_pos_q <= BIT_START)
    else $error("packet position out of range");

  a_preamble_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !reading_q |-> (byte_idx_q == '0 && bit_pos_q == '0))
    else $error("packet position left over in preamble mode");

  a_error_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == ST_BAD_BIT |-> res_q.packet_length == 3'd0)
    else $error("bit error carries a packet length");

endmodule

`default_nettype wire
